// File: design/rlefw_pkg.sv
`default_nettype none
package rlefw_pkg;

   // Field widths
   localparam int CODE_W   = 8;
   localparam int OFS_W    = 13;
   localparam int COUNT_W  = 6;
   localparam int LINE_W   = 8;

   // Defaults for the top-level parameters
   localparam int ROW_STRIDE_DEF  = 80;
   localparam int OFFSET_BITS_DEF = 13;

   // A byte at or above this mark is a repeat count when no count is armed
   localparam logic [CODE_W-1:0] COUNT_MARK = 8'd192;
   localparam logic [CODE_W-1:0] CODE_MAX   = 8'd255;

   // Row length after reset
   localparam logic [LINE_W-1:0] LINE_BYTES_RST = 8'd80;

   // Controller to datapath
   typedef struct packed {
      logic take;    // accept the input item and decode it
      logic write;   // emit one write into the output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic no_write;    // the offered item causes no write
      logic final_rep;   // the write in flight is the last for its item
      logic out_free;    // output register can take a write this cycle
   } ctrl_stat_type;

endpackage
`default_nettype wire

// File: design/rlefw_if.sv
`default_nettype none
interface rlefw_req_if;
   import rlefw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_byte;
   logic              end_of_image;

   modport source (output valid, output code_byte, output end_of_image, input ready);
   modport sink   (input valid, input code_byte, input end_of_image, output ready);
endinterface

interface rlefw_rsp_if;
   import rlefw_pkg::*;

   logic              valid;
   logic              ready;
   logic              bank;
   logic [OFS_W-1:0]  offset;
   logic [CODE_W-1:0] pixel_byte;
   logic              run_done;

   modport source (output valid, output bank, output offset, output pixel_byte,
                   output run_done, input ready);
   modport sink   (input valid, input bank, input offset, input pixel_byte,
                   input run_done, output ready);
endinterface
`default_nettype wire

// File: design/rlefw_ctrl.sv
`default_nettype none
module rlefw_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  rlefw_pkg::ctrl_stat_type stat,
   output rlefw_pkg::ctrl_cmd_type  cmd
);
   import rlefw_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Take an item only between runs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.take  = (state_ff == ST_IDLE) && req_valid;
      cmd.write = (state_ff == ST_EMIT) && stat.out_free;
   end

   // Advance between accepting and emitting
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && !stat.no_write) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.write && stat.final_rep) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: design/rlefw_dp.sv
`default_nettype none
module rlefw_dp #(
   parameter int ROW_STRIDE  = rlefw_pkg::ROW_STRIDE_DEF,
   parameter int OFFSET_BITS = rlefw_pkg::OFFSET_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [rlefw_pkg::LINE_W-1:0]        csr_wdata,
   input  wire  [rlefw_pkg::CODE_W-1:0]        code_byte,
   input  wire                                 end_of_image,
   input  rlefw_pkg::ctrl_cmd_type             cmd,
   output rlefw_pkg::ctrl_stat_type            stat,
   input  wire                                 rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_bank,
   output logic [rlefw_pkg::OFS_W-1:0]         rsp_offset,
   output logic [rlefw_pkg::CODE_W-1:0]        rsp_pixel_byte,
   output logic                                rsp_run_done
);
   import rlefw_pkg::*;

   localparam logic [OFFSET_BITS-1:0] STRIDE = OFFSET_BITS'(ROW_STRIDE);

   logic [LINE_W-1:0]      line_bytes_ff, line_bytes_in;
   logic [COUNT_W-1:0]     pend_ff, pend_in;
   logic                   armed_ff, armed_in;
   logic                   bank_ff, bank_in;
   logic [OFFSET_BITS-1:0] even_ff, even_in;
   logic [OFFSET_BITS-1:0] odd_ff, odd_in;
   logic [LINE_W-1:0]      column_ff, column_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic                   last_ff, last_in;
   logic [CODE_W-1:0]      data_ff, data_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_bank_ff, out_bank_in;
   logic [OFS_W-1:0]       out_ofs_ff, out_ofs_in;
   logic [CODE_W-1:0]      out_data_ff, out_data_in;
   logic                   out_done_ff, out_done_in;

   logic                   is_mark;
   logic [OFFSET_BITS-1:0] ptr, ptr_inc, ptr_row, ptr_nx;
   logic [LINE_W-1:0]      col_inc;
   logic                   row_end;

   // Decode the offered byte
   always_comb begin
      is_mark = code_byte inside {[COUNT_MARK:CODE_MAX]};
      stat.no_write  = !armed_ff && is_mark;
      stat.final_rep = (rem_ff == COUNT_W'(1));
      stat.out_free  = !out_valid_ff || rsp_ready;
   end

   // Next pointer of the active bank: step, or jump to the next row start
   always_comb begin
      ptr     = bank_ff ? odd_ff : even_ff;
      ptr_inc = ptr + OFFSET_BITS'(1);
      col_inc = column_ff + LINE_W'(1);
      row_end = (col_inc == line_bytes_ff);
      ptr_row = ptr_inc - OFFSET_BITS'(col_inc) + STRIDE;
      ptr_nx  = row_end ? ptr_row : ptr_inc;
   end

   always_comb begin
      line_bytes_in = line_bytes_ff;
      pend_in       = pend_ff;
      armed_in      = armed_ff;
      bank_in       = bank_ff;
      even_in       = even_ff;
      odd_in        = odd_ff;
      column_in     = column_ff;
      rem_in        = rem_ff;
      last_in       = last_ff;
      data_in       = data_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_bank_in   = out_bank_ff;
      out_ofs_in    = out_ofs_ff;
      out_data_in   = out_data_ff;
      out_done_in   = out_done_ff;

      if (csr_we) line_bytes_in = csr_wdata;

      // Accept: arm a count, or set up the run of writes
      if (cmd.take) begin
         data_in = code_byte;
         last_in = end_of_image;
         if (armed_ff) begin
            rem_in   = pend_ff;
            armed_in = 1'b0;
            pend_in  = '0;
         end else if (is_mark) begin
            pend_in  = code_byte[COUNT_W-1:0];
            armed_in = |code_byte[COUNT_W-1:0];
         end else begin
            rem_in = COUNT_W'(1);
         end
         // Clear the count and the row state when the final byte writes nothing
         if (stat.no_write && end_of_image) begin
            pend_in   = '0;
            armed_in  = 1'b0;
            bank_in   = 1'b0;
            even_in   = '0;
            odd_in    = '0;
            column_in = '0;
         end
      end

      // Emit one write and advance the active bank
      if (cmd.write) begin
         out_valid_in = 1'b1;
         out_bank_in  = bank_ff;
         out_ofs_in   = OFS_W'(ptr);
         out_data_in  = data_ff;
         out_done_in  = stat.final_rep;
         rem_in       = rem_ff - COUNT_W'(1);
         if (bank_ff) odd_in  = ptr_nx;
         else         even_in = ptr_nx;
         column_in = row_end ? '0 : col_inc;
         bank_in   = bank_ff ^ row_end;
         // Return to image start after the last write of the final byte
         if (stat.final_rep && last_ff) begin
            pend_in   = '0;
            armed_in  = 1'b0;
            bank_in   = 1'b0;
            even_in   = '0;
            odd_in    = '0;
            column_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff <= LINE_BYTES_RST;
         pend_ff       <= '0;
         armed_ff      <= 1'b0;
         bank_ff       <= 1'b0;
         even_ff       <= '0;
         odd_ff        <= '0;
         column_ff     <= '0;
         rem_ff        <= '0;
         last_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         line_bytes_ff <= line_bytes_in;
         pend_ff       <= pend_in;
         armed_ff      <= armed_in;
         bank_ff       <= bank_in;
         even_ff       <= even_in;
         odd_ff        <= odd_in;
         column_ff     <= column_in;
         rem_ff        <= rem_in;
         last_ff       <= last_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Hold the item payload and the output register
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      out_bank_ff <= out_bank_in;
      out_ofs_ff  <= out_ofs_in;
      out_data_ff <= out_data_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bank       = out_bank_ff;
   assign rsp_offset     = out_ofs_ff;
   assign rsp_pixel_byte = out_data_ff;
   assign rsp_run_done   = out_done_ff;

endmodule
`default_nettype wire

// File: design/rle_interlaced_frame_writer.sv
`default_nettype none
// Channel    Dir  Payload                                  Handshake
// req_chan   in   code_byte[7:0], end_of_image             valid/ready
// rsp_chan   out  bank, offset[12:0], pixel_byte, run_done valid/ready
// csr        in   csr_wdata[7:0] (line_bytes)              csr_we, no wait
//
// An item is taken in the idle state; a count byte ends there. A data byte then
// emits its writes from one output register, one per cycle while rsp_chan is
// not stalled: one write for a literal, up to 63 for a run.
// The controller takes no item while a run is being emitted.
// A stalled rsp_chan holds the output register and pauses the run.
// Synchronous active-high reset clears the row state and sets line_bytes to 80.
module rle_interlaced_frame_writer #(
   parameter int ROW_STRIDE  = rlefw_pkg::ROW_STRIDE_DEF,
   parameter int OFFSET_BITS = rlefw_pkg::OFFSET_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   rlefw_req_if.sink                    req_chan,
   rlefw_rsp_if.source                  rsp_chan,
   input  wire                          csr_we,
   input  wire [rlefw_pkg::LINE_W-1:0]  csr_wdata
);
   import rlefw_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic          req_ready;

   rlefw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlefw_dp #(
      .ROW_STRIDE  (ROW_STRIDE),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .code_byte      (req_chan.code_byte),
      .end_of_image   (req_chan.end_of_image),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_bank       (rsp_chan.bank),
      .rsp_offset     (rsp_chan.offset),
      .rsp_pixel_byte (rsp_chan.pixel_byte),
      .rsp_run_done   (rsp_chan.run_done)
   );

   assign req_chan.ready = req_ready;

endmodule
`default_nettype wire

// File: tb/sv/rle_interlaced_frame_writer_tb.sv
module rle_interlaced_frame_writer_tb;
   import rlefw_pkg::*;

   localparam int LONG_HOLD = 60;

   // One write into a frame bank, as seen on the result channel
   typedef struct packed {
      logic              bank;
      logic [OFS_W-1:0]  offset;
      logic [CODE_W-1:0] pixel_byte;
      logic              run_done;
   } frame_write_type;

   // Decode each accepted code byte into the bank writes it causes and
   // match them, in order, against the writes the block delivers
   class frame_scoreboard;
      logic [LINE_W-1:0]  line_bytes;
      logic [COUNT_W-1:0] run_count;
      bit                 count_armed;
      bit                 cur_bank;
      logic [OFS_W-1:0]   even_ptr;
      logic [OFS_W-1:0]   odd_ptr;
      logic [LINE_W-1:0]  column;
      frame_write_type    writes_due[$];
      int                 mismatches;
      int                 bytes_taken;
      int                 writes_checked;
      int                 runs_seen;
      int                 images_ended;

      function new();
         line_bytes = LINE_BYTES_RST;
         restart_image();
      endfunction

      function void restart_image();
         run_count   = '0;
         count_armed = 1'b0;
         cur_bank    = 1'b0;
         even_ptr    = '0;
         odd_ptr     = '0;
         column      = '0;
      endfunction

      // Queue one write at the active bank, then advance its pointer
      function void place_write(logic [CODE_W-1:0] data, bit last);
         frame_write_type w;
         int              p;
         p            = int'(cur_bank ? odd_ptr : even_ptr);
         w.bank       = cur_bank;
         w.offset     = p[OFS_W-1:0];
         w.pixel_byte = data;
         w.run_done   = last;
         writes_due.push_back(w);
         p      = p + 1;
         column = column + 1'b1;
         // end of row: jump to row start plus stride and switch banks
         if (column == line_bytes) begin
            p      = p - column + ROW_STRIDE_DEF;
            column = '0;
            if (cur_bank) odd_ptr = p[OFS_W-1:0];
            else          even_ptr = p[OFS_W-1:0];
            cur_bank = ~cur_bank;
         end else if (cur_bank) begin
            odd_ptr = p[OFS_W-1:0];
         end else begin
            even_ptr = p[OFS_W-1:0];
         end
      endfunction

      function void take_code_byte(logic [CODE_W-1:0] code, logic eoi);
         int reps;
         reps = 0;
         bytes_taken++;
         if (count_armed) begin
            // armed count: this byte is data, whatever its value
            reps        = int'(run_count);
            count_armed = 1'b0;
            run_count   = '0;
            runs_seen++;
         end else if (code >= COUNT_MARK) begin
            // a zero count arms nothing
            run_count   = code[COUNT_W-1:0];
            count_armed = (run_count != 0);
         end else begin
            reps = 1;
         end
         for (int k = 0; k < reps; k++)
            place_write(code, k == reps - 1);
         if (eoi) begin
            restart_image();
            images_ended++;
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: %s", msg);
      endfunction

      function void check_write(frame_write_type got);
         frame_write_type exp;
         writes_checked++;
         if (writes_due.size() == 0) begin
            flag($sformatf("write with nothing expected: bank %0d offset %0d byte %02h done %0d",
                           got.bank, got.offset, got.pixel_byte, got.run_done));
            return;
         end
         exp = writes_due.pop_front();
         if (got.bank !== exp.bank || got.offset !== exp.offset ||
             got.pixel_byte !== exp.pixel_byte || got.run_done !== exp.run_done)
            flag($sformatf({"write %0d: expected bank %0d offset %0d byte %02h done %0d,",
                            " got bank %0d offset %0d byte %02h done %0d"},
                           writes_checked, exp.bank, exp.offset, exp.pixel_byte, exp.run_done,
                           got.bank, got.offset, got.pixel_byte, got.run_done));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [LINE_W-1:0] csr_wdata;
   bit                idling_on = 1'b1;
   bit                hold_rsp_long = 1'b0;
   int                codes_sent = 0;
   logic [LINE_W-1:0] mid_len;
   logic [LINE_W-1:0] last_len;
   frame_scoreboard   board = new();

   rlefw_req_if req_chan();
   rlefw_rsp_if rsp_chan();

   rle_interlaced_frame_writer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels; results first, then the item taken at this edge
   always @(posedge clock) begin
      frame_write_type got;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.bank       = rsp_chan.bank;
            got.offset     = rsp_chan.offset;
            got.pixel_byte = rsp_chan.pixel_byte;
            got.run_done   = rsp_chan.run_done;
            board.check_write(got);
         end
         if (req_chan.valid && req_chan.ready)
            board.take_code_byte(req_chan.code_byte, req_chan.end_of_image);
      end
   end

   // Drive ready: long hold on request, random stall bursts while idling is on
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_long) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_long = 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one code byte, with a random gap ahead of it, and hold until taken
   task automatic send_code(input logic [CODE_W-1:0] code, input logic eoi);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.code_byte    <= code;
      req_chan.end_of_image <= eoi;
      do @(posedge clock); while (!req_chan.ready);
      codes_sent++;
   endtask

   // Stop offering, wait for every pending write, then let a count byte settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.writes_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_line_bytes(input logic [LINE_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.line_bytes = value;
   endtask

   function automatic logic end_mark();
      return $urandom_range(0, 15) == 0;
   endfunction

   // One random construct: mostly literals and count/data pairs, some noise
   task automatic random_sequence();
      int                 kind;
      logic [COUNT_W-1:0] len;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         send_code(CODE_W'($urandom_range(0, COUNT_MARK - 1)), end_mark());
      end else if (kind <= 7) begin
         if ($urandom_range(0, 3) == 0) len = COUNT_W'($urandom_range(1, 63));
         else                           len = COUNT_W'($urandom_range(1, 8));
         send_code(COUNT_MARK | {2'b00, len}, $urandom_range(0, 31) == 0);
         send_code(CODE_W'($urandom_range(0, CODE_MAX)), end_mark());
      end else if (kind == 8) begin
         send_code(COUNT_MARK, 1'b0);
      end else begin
         send_code(CODE_W'($urandom_range(0, CODE_MAX)), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic fill(input int n);
      int stop;
      stop = codes_sent + n;
      while (codes_sent < stop)
         random_sequence();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.code_byte    <= '0;
      req_chan.end_of_image <= 1'b0;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: literal extremes, runs, zero count, count byte as data
      send_code(8'h00, 1'b0);
      send_code(CODE_W'(COUNT_MARK - 1), 1'b0);
      send_code(COUNT_MARK | 8'd3, 1'b0);
      send_code(CODE_MAX, 1'b0);
      send_code(COUNT_MARK, 1'b0);
      send_code(8'h55, 1'b0);
      send_code(COUNT_MARK, 1'b0);
      send_code(COUNT_MARK | 8'd2, 1'b0);
      send_code(COUNT_MARK | 8'd21, 1'b0);
      // longest run
      send_code(CODE_MAX, 1'b0);
      send_code(8'hAA, 1'b0);
      // end of image on a count byte, on run data, on a literal
      send_code(COUNT_MARK | 8'd5, 1'b1);
      send_code(8'h12, 1'b0);
      send_code(COUNT_MARK | 8'd2, 1'b0);
      send_code(8'h7E, 1'b1);
      send_code(8'h34, 1'b1);

      // One-byte rows: long runs walk both pointers past the offset wrap
      write_line_bytes(8'd1);
      repeat (4) begin
         send_code(CODE_MAX, 1'b0);
         send_code(CODE_W'($urandom_range(0, CODE_MAX)), 1'b0);
      end

      // Register value zero gives 256-byte rows
      write_line_bytes(8'd0);
      fill(20);

      // 255-byte rows; hold the result side off while items keep coming
      write_line_bytes(8'd255);
      hold_rsp_long = 1'b1;
      send_code(CODE_MAX, 1'b0);
      send_code(CODE_W'($urandom_range(0, CODE_MAX)), 1'b0);
      fill(10);
      wait_drained();
      fill(13);

      mid_len = LINE_W'($urandom_range(2, 24));
      write_line_bytes(mid_len);
      fill(20);

      // Last part runs at full rate on both sides
      idling_on = 1'b0;
      last_len  = LINE_W'($urandom_range(1, 255));
      write_line_bytes(last_len);
      fill(20);

      wait_drained();
      repeat (8) @(posedge clock);
      if (board.writes_due.size() != 0)
         board.flag($sformatf("%0d writes never arrived", board.writes_due.size()));

      $display("decoded %0d code bytes (%0d runs, %0d image ends) into %0d checked writes",
               board.bytes_taken, board.runs_seen, board.images_ended, board.writes_checked);
      $display("row lengths 80, 1 (offset wrap), 256, 255, %0d and %0d; %0d mismatches",
               mid_len, last_len, board.mismatches);
      if (board.mismatches == 0)
         $display("[rle_interlaced_frame_writer] OK");
      else
         $display("[rle_interlaced_frame_writer] ERROR");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5000000;
      $display("[rle_interlaced_frame_writer] ERROR");
      $finish;
   end

endmodule
